// ===== hdl/pmbt_pkg.sv =====
// ---------------------------------------------------------------------------
// pmbt_pkg
// Shared types, field widths and codes of the prism modal backward transform.
// ---------------------------------------------------------------------------
package pmbt_pkg;

	localparam int CMD_W    = 3;
	localparam int SLOT_W   = 12;
	localparam int SAMPLE_W = 32;
	localparam int ACC_W    = 48;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_X    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_Y    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD_Z    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMPUTE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MODES_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODES_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODES_C  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Z = 3'd5;

	localparam logic [CFG_W-1:0] MODES_RESET  = 5'd4;
	localparam logic [CFG_W-1:0] POINTS_RESET = 5'd5;

	localparam logic [1:0] PH_Z = 2'd0;
	localparam logic [1:0] PH_Y = 2'd1;
	localparam logic [1:0] PH_X = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic       valid;
		logic [1:0] phase;
		logic       first;
		logic       last;
		logic       empty;
	} step_ctl_t;

endpackage

// ===== hdl/pmbt_cmd_if.sv =====
// ---------------------------------------------------------------------------
// pmbt_cmd_if
// Command channel: valid/ready handshake with command, slot and sample.
// ---------------------------------------------------------------------------
interface pmbt_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [pmbt_pkg::CMD_W-1:0]        command;
	logic [pmbt_pkg::SLOT_W-1:0]       slot;
	logic signed [pmbt_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, command, slot, sample, input ready);
	modport sink (input valid, command, slot, sample, output ready);
endinterface

interface pmbt_pt_if;
	logic                              valid;
	logic                              ready;
	logic [pmbt_pkg::SLOT_W-1:0]       point_number;
	logic signed [pmbt_pkg::SAMPLE_W-1:0] point_value;

	modport source (output valid, point_number, point_value, input ready);
	modport sink (input valid, point_number, point_value, output ready);
endinterface

// ===== hdl/pmbt_datapath.sv =====
// ---------------------------------------------------------------------------
// pmbt_datapath
// Tables, partial-sum stores, split multiplier, saturating accumulator and
// the registered point read path.
// ---------------------------------------------------------------------------
module pmbt_datapath #(
	parameter int MAX_MODES  = 16,
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 24,
	parameter int COEF_AW    = 12,
	parameter int XB_AW      = 8,
	parameter int ZB_AW      = 12,
	parameter int ZPS_AW     = 8,
	parameter int YZ_AW      = 4,
	parameter int PT_AW      = 12,
	parameter int DEST_W     = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_accept,
	input  logic [pmbt_pkg::CMD_W-1:0]             command,
	input  logic [pmbt_pkg::SLOT_W-1:0]            slot,
	input  logic signed [pmbt_pkg::SAMPLE_W-1:0]   sample,
	input  pmbt_pkg::step_ctl_t                    step,
	input  logic [COEF_AW-1:0]                     coef_addr,
	input  logic [ZB_AW-1:0]                       zb_addr,
	input  logic [ZPS_AW-1:0]                      zps_addr,
	input  logic [XB_AW-1:0]                       yb_addr,
	input  logic [YZ_AW-1:0]                       yz_addr,
	input  logic [XB_AW-1:0]                       xb_addr,
	input  logic [DEST_W-1:0]                      dest,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pmbt_pkg::SLOT_W-1:0]            out_number,
	output logic signed [pmbt_pkg::SAMPLE_W-1:0]   out_value,
	output logic                                   out_busy
);
	localparam int COEF_DEPTH = MAX_MODES * MAX_MODES * MAX_MODES;
	localparam int XY_DEPTH   = MAX_MODES * MAX_POINTS;
	localparam int Z_DEPTH    = MAX_MODES * MAX_MODES * MAX_POINTS;
	localparam int PT_DEPTH   = MAX_POINTS * MAX_POINTS * MAX_POINTS;
	localparam int ZPS_DEPTH  = MAX_MODES * MAX_MODES;
	localparam int AW = pmbt_pkg::ACC_W;
	localparam int SW = pmbt_pkg::SAMPLE_W;
	localparam int HALF = AW / 2;
	localparam int PW = HALF + SW;
	localparam int FW = AW + SW;
	localparam logic signed [AW-1:0] PT_HI = AW'(32'sh7FFF_FFFF);
	localparam logic signed [AW-1:0] PT_LO = ~PT_HI;

	logic signed [SW-1:0] coef_mem [COEF_DEPTH];
	logic signed [SW-1:0] xb_mem [XY_DEPTH];
	logic signed [SW-1:0] yb_mem [XY_DEPTH];
	logic signed [SW-1:0] zb_mem [Z_DEPTH];
	logic signed [AW-1:0] zps_mem [ZPS_DEPTH];
	logic signed [AW-1:0] yz_mem [MAX_MODES];
	logic signed [SW-1:0] pt_mem [PT_DEPTH];

	logic in_range;
	logic [pmbt_pkg::SLOT_W:0] slot_x;

	// loads
	always_ff @(posedge clk) begin
		if (cmd_accept && command == pmbt_pkg::CMD_LOAD_COEF && slot_x < (COEF_DEPTH)) begin
			coef_mem[COEF_AW'(slot)] <= sample;
		end
		if (cmd_accept && command == pmbt_pkg::CMD_LOAD_X && slot_x < (XY_DEPTH)) begin
			xb_mem[XB_AW'(slot)] <= sample;
		end
		if (cmd_accept && command == pmbt_pkg::CMD_LOAD_Y && slot_x < (XY_DEPTH)) begin
			yb_mem[XB_AW'(slot)] <= sample;
		end
		if (cmd_accept && command == pmbt_pkg::CMD_LOAD_Z && slot_x < (Z_DEPTH)) begin
			zb_mem[ZB_AW'(slot)] <= sample;
		end
	end

	assign slot_x = {1'b0, slot};
	assign in_range = slot_x < (PT_DEPTH);

	// stage 1: table reads
	logic signed [SW-1:0] coef_s1, xb_s1, yb_s1, zb_s1;
	logic signed [AW-1:0] zps_s1, yz_s1;
	pmbt_pkg::step_ctl_t  ctl_s1, ctl_s2, ctl_s3;
	logic [DEST_W-1:0]    dest_s1, dest_s2, dest_s3;

	always_ff @(posedge clk) begin
		coef_s1 <= coef_mem[coef_addr];
		zb_s1   <= zb_mem[zb_addr];
		zps_s1  <= zps_mem[zps_addr];
		yb_s1   <= yb_mem[yb_addr];
		yz_s1   <= yz_mem[yz_addr];
		xb_s1   <= xb_mem[xb_addr];
		dest_s1 <= dest;
		dest_s2 <= dest_s1;
		dest_s3 <= dest_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= step;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// stage 2: magnitudes and two partial products
	logic signed [AW-1:0] op_a;
	logic signed [SW-1:0] op_b;
	logic [AW-1:0] ua;
	logic [SW-1:0] ub;
	logic [PW-1:0] hp_s2, lp_s2;
	logic          neg_s2;

	always_comb begin
		case (ctl_s1.phase)
			pmbt_pkg::PH_Z: begin
				op_a = AW'(coef_s1);
				op_b = zb_s1;
			end
			pmbt_pkg::PH_Y: begin
				op_a = zps_s1;
				op_b = yb_s1;
			end
			default: begin
				op_a = yz_s1;
				op_b = xb_s1;
			end
		endcase
		ua = op_a[AW-1] ? AW'(-op_a) : AW'(op_a);
		ub = op_b[SW-1] ? SW'(-op_b) : SW'(op_b);
	end

	always_ff @(posedge clk) begin
		hp_s2  <= PW'(ua[AW-1:HALF]) * PW'(ub);
		lp_s2  <= PW'(ua[HALF-1:0]) * PW'(ub);
		neg_s2 <= op_a[AW-1] ^ op_b[SW-1];
	end

	// stage 3: recombine, round toward minus infinity, saturate
	logic [FW-1:0] full;
	logic [FW-1:0] quo;
	logic          rem_nz;
	logic          big;
	logic [AW:0]   mag;
	logic signed [AW-1:0] prod;
	logic signed [AW-1:0] prod_s3;

	always_comb begin
		full   = (FW'(hp_s2) << HALF) + FW'(lp_s2);
		quo    = full >> FRAC_BITS;
		rem_nz = |full[FRAC_BITS-1:0];
		big    = |quo[FW-1:AW];
		mag    = (AW+1)'(quo[AW-1:0]) + (AW+1)'(rem_nz);
		if (big) begin
			prod = neg_s2 ? pmbt_pkg::ACC_MIN : pmbt_pkg::ACC_MAX;
		end else if (neg_s2) begin
			if (mag[AW] || (mag[AW-1] && |mag[AW-2:0])) begin
				prod = pmbt_pkg::ACC_MIN;
			end else begin
				prod = AW'(-mag);
			end
		end else begin
			prod = quo[AW-1] ? pmbt_pkg::ACC_MAX : quo[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= ctl_s2.empty ? '0 : prod;
	end

	// accumulate and write back
	logic signed [AW-1:0] acc_q;
	logic signed [AW:0]   sum;
	logic signed [AW-1:0] acc_next;
	logic signed [SW-1:0] acc32;

	always_comb begin
		sum = (AW+1)'(acc_q) + (AW+1)'(prod_s3);
		if (ctl_s3.first) begin
			acc_next = prod_s3;
		end else if (sum[AW] != sum[AW-1]) begin
			acc_next = sum[AW] ? pmbt_pkg::ACC_MIN : pmbt_pkg::ACC_MAX;
		end else begin
			acc_next = sum[AW-1:0];
		end
		if (acc_next > PT_HI) begin
			acc32 = PT_HI[SW-1:0];
		end else if (acc_next < PT_LO) begin
			acc32 = PT_LO[SW-1:0];
		end else begin
			acc32 = acc_next[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			acc_q <= acc_next;
		end
		if (ctl_s3.valid && ctl_s3.last && ctl_s3.phase == pmbt_pkg::PH_Z) begin
			zps_mem[ZPS_AW'(dest_s3)] <= acc_next;
		end
		if (ctl_s3.valid && ctl_s3.last && ctl_s3.phase == pmbt_pkg::PH_Y) begin
			yz_mem[YZ_AW'(dest_s3)] <= acc_next;
		end
		if (ctl_s3.valid && ctl_s3.last && ctl_s3.phase == pmbt_pkg::PH_X) begin
			pt_mem[PT_AW'(dest_s3)] <= acc32;
		end
	end

	// point read path, the read register doubles as output register
	logic rd_take;
	logic signed [SW-1:0] rd_data_q;
	logic rd_zero_q;

	assign rd_take = cmd_accept && command == pmbt_pkg::CMD_READ;

	always_ff @(posedge clk) begin
		if (rd_take) begin
			rd_data_q  <= pt_mem[PT_AW'(slot)];
			rd_zero_q  <= !in_range;
			out_number <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rd_take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	assign out_value = rd_zero_q ? '0 : rd_data_q;
	assign out_busy  = out_valid && !out_ready;

endmodule

// ===== hdl/pmbt_controller.sv =====
// ---------------------------------------------------------------------------
// pmbt_controller
// Configuration registers and the loop sequencer that walks z, y and x
// contractions, one multiply-accumulate step per cycle between drains.
// ---------------------------------------------------------------------------
module pmbt_controller #(
	parameter int MAX_MODES  = 16,
	parameter int MAX_POINTS = 16,
	parameter int COEF_AW    = 12,
	parameter int XB_AW      = 8,
	parameter int ZB_AW      = 12,
	parameter int ZPS_AW     = 8,
	parameter int YZ_AW      = 4,
	parameter int PT_AW      = 12,
	parameter int DEST_W     = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pmbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmbt_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                start,
	output logic                                idle,
	output pmbt_pkg::step_ctl_t                 step,
	output logic [COEF_AW-1:0]                  coef_addr,
	output logic [ZB_AW-1:0]                    zb_addr,
	output logic [ZPS_AW-1:0]                   zps_addr,
	output logic [XB_AW-1:0]                    yb_addr,
	output logic [YZ_AW-1:0]                    yz_addr,
	output logic [XB_AW-1:0]                    xb_addr,
	output logic [DEST_W-1:0]                   dest
);
	localparam int NW = $clog2(MAX_MODES + 1);
	localparam int QW = $clog2(MAX_POINTS + 1);
	localparam int CW = pmbt_pkg::CFG_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_Z    = 3'd1;
	localparam logic [2:0] ST_ZD   = 3'd2;
	localparam logic [2:0] ST_Y    = 3'd3;
	localparam logic [2:0] ST_YD   = 3'd4;
	localparam logic [2:0] ST_X    = 3'd5;
	localparam logic [2:0] ST_XD   = 3'd6;

	logic [CW-1:0] modes_a_q, modes_b_q, modes_c_q;
	logic [CW-1:0] points_x_q, points_y_q, points_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_a_q  <= pmbt_pkg::MODES_RESET;
			modes_b_q  <= pmbt_pkg::MODES_RESET;
			modes_c_q  <= pmbt_pkg::MODES_RESET;
			points_x_q <= pmbt_pkg::POINTS_RESET;
			points_y_q <= pmbt_pkg::POINTS_RESET;
			points_z_q <= pmbt_pkg::POINTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pmbt_pkg::CFG_MODES_A:  modes_a_q  <= cfg_data;
				pmbt_pkg::CFG_MODES_B:  modes_b_q  <= cfg_data;
				pmbt_pkg::CFG_MODES_C:  modes_c_q  <= cfg_data;
				pmbt_pkg::CFG_POINTS_X: points_x_q <= cfg_data;
				pmbt_pkg::CFG_POINTS_Y: points_y_q <= cfg_data;
				pmbt_pkg::CFG_POINTS_Z: points_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective counts: zero acts as one, large values clip to the maximum
	logic [NW-1:0] na, nb, nc;
	logic [QW-1:0] qx, qy, qz;

	always_comb begin
		na = (modes_a_q == '0) ? NW'(1) : ((modes_a_q > MAX_MODES) ? NW'(MAX_MODES) : NW'(modes_a_q));
		nb = (modes_b_q == '0) ? NW'(1) : ((modes_b_q > MAX_MODES) ? NW'(MAX_MODES) : NW'(modes_b_q));
		nc = (modes_c_q == '0) ? NW'(1) : ((modes_c_q > MAX_MODES) ? NW'(MAX_MODES) : NW'(modes_c_q));
		qx = (points_x_q == '0) ? QW'(1) : ((points_x_q > MAX_POINTS) ? QW'(MAX_POINTS) : QW'(points_x_q));
		qy = (points_y_q == '0) ? QW'(1) : ((points_y_q > MAX_POINTS) ? QW'(MAX_POINTS) : QW'(points_y_q));
		qz = (points_z_q == '0) ? QW'(1) : ((points_z_q > MAX_POINTS) ? QW'(MAX_POINTS) : QW'(points_z_q));
	end

	logic [2:0]         state_q;
	logic [1:0]         drn_q;
	logic [NW-1:0]      p_q, q_q, r_q;
	logic [QW-1:0]      i_q, j_q, k_q;
	logic [COEF_AW-1:0] m_q;
	logic [ZB_AW-1:0]   zaddr_q, zbase_q;
	logic [ZPS_AW-1:0]  zs_q, ys_q;
	logic [XB_AW-1:0]   yaddr_q, xaddr_q;
	logic [PT_AW-1:0]   pt_q;
	logic [NW-1:0]      rn;
	logic               empty;
	logic               drained;

	assign rn      = (p_q < nc) ? NW'(nc - p_q) : '0;
	assign empty   = (rn == '0);
	assign drained = (drn_q == 2'd2);
	assign idle    = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drn_q   <= '0;
			p_q     <= '0;
			q_q     <= '0;
			r_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			m_q     <= '0;
			zaddr_q <= '0;
			zbase_q <= '0;
			zs_q    <= '0;
			ys_q    <= '0;
			yaddr_q <= '0;
			xaddr_q <= '0;
			pt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_Z;
						k_q     <= '0;
						j_q     <= '0;
						pt_q    <= '0;
						p_q     <= '0;
						q_q     <= '0;
						r_q     <= '0;
						m_q     <= '0;
						zs_q    <= '0;
						zbase_q <= '0;
						zaddr_q <= '0;
					end
				end
				ST_Z: begin
					if (!empty && (r_q + 1'b1) != rn) begin
						r_q     <= r_q + 1'b1;
						m_q     <= m_q + 1'b1;
						zaddr_q <= zaddr_q + ZB_AW'(qz);
					end else begin
						r_q  <= '0;
						zs_q <= zs_q + 1'b1;
						if (!empty) begin
							m_q <= m_q + 1'b1;
						end
						if ((q_q + 1'b1) != nb) begin
							q_q     <= q_q + 1'b1;
							zaddr_q <= zbase_q;
						end else begin
							q_q <= '0;
							if (!empty) begin
								zbase_q <= zaddr_q + ZB_AW'(qz);
								zaddr_q <= zaddr_q + ZB_AW'(qz);
							end else begin
								zaddr_q <= zbase_q;
							end
							if ((p_q + 1'b1) != na) begin
								p_q <= p_q + 1'b1;
							end else begin
								p_q     <= '0;
								drn_q   <= '0;
								state_q <= ST_ZD;
							end
						end
					end
				end
				ST_ZD: begin
					drn_q <= drn_q + 1'b1;
					if (drained) begin
						state_q <= ST_Y;
						p_q     <= '0;
						q_q     <= '0;
						ys_q    <= '0;
						yaddr_q <= XB_AW'(j_q);
					end
				end
				ST_Y: begin
					ys_q <= ys_q + 1'b1;
					if ((q_q + 1'b1) != nb) begin
						q_q     <= q_q + 1'b1;
						yaddr_q <= yaddr_q + XB_AW'(qy);
					end else begin
						q_q     <= '0;
						yaddr_q <= XB_AW'(j_q);
						if ((p_q + 1'b1) != na) begin
							p_q <= p_q + 1'b1;
						end else begin
							p_q     <= '0;
							drn_q   <= '0;
							state_q <= ST_YD;
						end
					end
				end
				ST_YD: begin
					drn_q <= drn_q + 1'b1;
					if (drained) begin
						state_q <= ST_X;
						p_q     <= '0;
						i_q     <= '0;
						xaddr_q <= '0;
					end
				end
				ST_X: begin
					if ((p_q + 1'b1) != na) begin
						p_q     <= p_q + 1'b1;
						xaddr_q <= xaddr_q + XB_AW'(qx);
					end else begin
						p_q  <= '0;
						pt_q <= pt_q + 1'b1;
						if ((i_q + 1'b1) != qx) begin
							i_q     <= i_q + 1'b1;
							xaddr_q <= XB_AW'(i_q) + 1'b1;
						end else begin
							i_q     <= '0;
							drn_q   <= '0;
							state_q <= ST_XD;
						end
					end
				end
				ST_XD: begin
					drn_q <= drn_q + 1'b1;
					if (drained) begin
						if ((j_q + 1'b1) != qy) begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_Y;
							p_q     <= '0;
							q_q     <= '0;
							ys_q    <= '0;
							yaddr_q <= XB_AW'(j_q) + 1'b1;
						end else begin
							j_q <= '0;
							if ((k_q + 1'b1) != qz) begin
								k_q     <= k_q + 1'b1;
								state_q <= ST_Z;
								p_q     <= '0;
								q_q     <= '0;
								r_q     <= '0;
								m_q     <= '0;
								zs_q    <= '0;
								zbase_q <= ZB_AW'(k_q) + 1'b1;
								zaddr_q <= ZB_AW'(k_q) + 1'b1;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		step       = '0;
		step.valid = (state_q == ST_Z) || (state_q == ST_Y) || (state_q == ST_X);
		dest       = '0;
		unique case (state_q)
			ST_Z: begin
				step.phase = pmbt_pkg::PH_Z;
				step.first = (r_q == '0);
				step.last  = empty || ((r_q + 1'b1) == rn);
				step.empty = empty;
				dest       = DEST_W'(zs_q);
			end
			ST_Y: begin
				step.phase = pmbt_pkg::PH_Y;
				step.first = (q_q == '0);
				step.last  = ((q_q + 1'b1) == nb);
				dest       = DEST_W'(p_q);
			end
			ST_X: begin
				step.phase = pmbt_pkg::PH_X;
				step.first = (p_q == '0);
				step.last  = ((p_q + 1'b1) == na);
				dest       = DEST_W'(pt_q);
			end
			default: ;
		endcase
	end

	assign coef_addr = m_q;
	assign zb_addr   = zaddr_q;
	assign zps_addr  = ys_q;
	assign yb_addr   = yaddr_q;
	assign yz_addr   = YZ_AW'(p_q);
	assign xb_addr   = xaddr_q;

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Z || state_q == ST_Y || state_q == ST_X) |-> (p_q < na && q_q < nb))
		else $error("mode counter outside configured range");
	a_point_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X) |-> (i_q < qx && j_q < qy && k_q < qz))
		else $error("point counter outside configured range");
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XD && drained && (j_q + 1'b1) == qy && (k_q + 1'b1) == qz)
		|=> (state_q == ST_IDLE))
		else $error("compute did not return to idle after last point");
	a_z_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_Z) |-> (p_q == '0 && q_q == '0 && r_q == '0 && m_q == '0))
		else $error("z contraction did not start at the first coefficient");

endmodule

// ===== hdl/prism_modal_backward_transform.sv =====
// ---------------------------------------------------------------------------
// prism_modal_backward_transform
// Prism modal backward transform by sum factorization, Q8.24 fixed point.
// ---------------------------------------------------------------------------
// Usage: write the six size registers through cfg_we/cfg_index/cfg_data while
// the block is idle, then send transactions on cmd_in: load coefficient,
// load x/y/z basis entry, compute, read point. Loads and reads are taken one
// per cycle while the block is idle. A read answers on pt_out in the cycle after
// it is taken, from a registered read of the point store that also serves as
// the output register. When pt_out stalls, loads and compute still go ahead;
// a further read waits until the held transaction is taken.
// A compute keeps cmd_in not ready until the sequencer is idle again: the
// sequencer issues one multiply-accumulate per cycle into a four-stage
// pipeline (table read, split multiply, round and saturate, accumulate)
// and waits for it to empty between contractions.
// Reset returns the registers to 4/4/4/5/5/5 and the sequencer to idle;
// the tables and stores hold no defined contents until written.
// ---------------------------------------------------------------------------
module prism_modal_backward_transform #(
	parameter int MAX_MODES  = 16,
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pmbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmbt_pkg::CFG_W-1:0]        cfg_data,
	pmbt_cmd_if.sink                          cmd_in,
	pmbt_pt_if.source                         pt_out
);
	localparam int COEF_AW = $clog2(MAX_MODES * MAX_MODES * MAX_MODES);
	localparam int XB_AW   = $clog2(MAX_MODES * MAX_POINTS);
	localparam int ZB_AW   = $clog2(MAX_MODES * MAX_MODES * MAX_POINTS);
	localparam int ZPS_AW  = $clog2(MAX_MODES * MAX_MODES);
	localparam int YZ_AW   = $clog2(MAX_MODES);
	localparam int PT_AW   = $clog2(MAX_POINTS * MAX_POINTS * MAX_POINTS);
	localparam int DEST_W  = (PT_AW > ZPS_AW) ? PT_AW : ZPS_AW;

	logic                idle;
	logic                out_busy;
	logic                cmd_accept;
	pmbt_pkg::step_ctl_t step;
	logic [COEF_AW-1:0]  coef_addr;
	logic [ZB_AW-1:0]    zb_addr;
	logic [ZPS_AW-1:0]   zps_addr;
	logic [XB_AW-1:0]    yb_addr;
	logic [YZ_AW-1:0]    yz_addr;
	logic [XB_AW-1:0]    xb_addr;
	logic [DEST_W-1:0]   dest;

	assign cmd_in.ready = idle && !(cmd_in.command == pmbt_pkg::CMD_READ && out_busy);
	assign cmd_accept   = cmd_in.valid && cmd_in.ready;

	pmbt_controller #(
		.MAX_MODES (MAX_MODES),
		.MAX_POINTS(MAX_POINTS),
		.COEF_AW   (COEF_AW),
		.XB_AW     (XB_AW),
		.ZB_AW     (ZB_AW),
		.ZPS_AW    (ZPS_AW),
		.YZ_AW     (YZ_AW),
		.PT_AW     (PT_AW),
		.DEST_W    (DEST_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (cmd_accept && cmd_in.command == pmbt_pkg::CMD_COMPUTE),
		.idle      (idle),
		.step      (step),
		.coef_addr (coef_addr),
		.zb_addr   (zb_addr),
		.zps_addr  (zps_addr),
		.yb_addr   (yb_addr),
		.yz_addr   (yz_addr),
		.xb_addr   (xb_addr),
		.dest      (dest)
	);

	pmbt_datapath #(
		.MAX_MODES (MAX_MODES),
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS),
		.COEF_AW   (COEF_AW),
		.XB_AW     (XB_AW),
		.ZB_AW     (ZB_AW),
		.ZPS_AW    (ZPS_AW),
		.YZ_AW     (YZ_AW),
		.PT_AW     (PT_AW),
		.DEST_W    (DEST_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_accept (cmd_accept),
		.command    (cmd_in.command),
		.slot       (cmd_in.slot),
		.sample     (cmd_in.sample),
		.step       (step),
		.coef_addr  (coef_addr),
		.zb_addr    (zb_addr),
		.zps_addr   (zps_addr),
		.yb_addr    (yb_addr),
		.yz_addr    (yz_addr),
		.xb_addr    (xb_addr),
		.dest       (dest),
		.out_valid  (pt_out.valid),
		.out_ready  (pt_out.ready),
		.out_number (pt_out.point_number),
		.out_value  (pt_out.point_value),
		.out_busy   (out_busy)
	);

endmodule
